/* design/popc_pkg.sv */
// Package for the path obstacle proximity check: request codes, beat struct,
// register indexes and reset values. Used by every module in design/ except popc_isqrt.
package popc_pkg;

	localparam int PathDepthDef = 1024;
	localparam int ScanDepthDef = 1024;
	localparam int QueueDepth   = 4;

	typedef enum logic [1:0] {
		REQ_PATH = 2'd0,
		REQ_SCAN = 2'd1,
		REQ_EOF  = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	localparam logic [2:0] REG_CUT     = 3'd0;
	localparam logic [2:0] REG_BOX     = 3'd1;
	localparam logic [2:0] REG_RADIUS  = 3'd2;
	localparam logic [2:0] REG_LIMIT   = 3'd3;
	localparam logic [2:0] REG_CONFIRM = 3'd4;

	localparam logic [14:0] CUT_RST     = 15'd3800;
	localparam logic [14:0] BOX_RST     = 15'd800;
	localparam logic [14:0] RADIUS_RST  = 15'd185;
	localparam logic [15:0] LIMIT_RST   = 16'd20000;
	localparam logic [3:0]  CONFIRM_RST = 4'd4;

	typedef struct packed {
		req_t               req;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               first;
	} beat_t;

	typedef struct packed {
		logic               confirmed;
		logic [15:0]        range_cm;
		logic               raw_hit;
		logic signed [15:0] hit_x;
		logic signed [15:0] hit_y;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRD,
		ST_PCHK,
		ST_SRD,
		ST_SCHK,
		ST_SQ1,
		ST_SQ2,
		ST_ROOT,
		ST_DONE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [14:0] cut;
		logic [14:0] box;
		logic [14:0] radius;
		logic [15:0] limit;
		logic [3:0]  confirm;
	} cfg_t;

endpackage

/* design/path_obstacle_proximity_check.sv */
// Top level of the path obstacle proximity check: config registers,
// front queue and back-end search. Depends on popc_pkg, popc_front, popc_back.
//
//  channel | handshake        | beat
//  in      | push / full      | req_type, point_x_cm, point_y_cm, first_of_set
//  out     | pop / empty      | confirmed, range_cm, raw_hit, hit_x_cm, hit_y_cm
//  cfg     | cfg_valid/ready  | cfg_index, cfg_data
//
// Load beats are taken only while the back end is idle. At end of frame the
// search visits path points (skipped or searched) and path/scan pairs, then
// takes the root on a hit and posts the result; the search loop reads the
// single-port stores.
// Reset clears counts, confirmation counter and held hit point; stores are
// not cleared. The input queue keeps taking beats while a result waits.
module path_obstacle_proximity_check #(
	parameter int PATH_DEPTH = popc_pkg::PathDepthDef,
	parameter int SCAN_DEPTH = popc_pkg::ScanDepthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] point_x_cm,
	input  logic signed [15:0] point_y_cm,
	input  logic               first_of_set,
	output logic               empty,
	input  logic               pop,
	output logic               confirmed,
	output logic [15:0]        range_cm,
	output logic               raw_hit,
	output logic signed [15:0] hit_x_cm,
	output logic signed [15:0] hit_y_cm,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	popc_pkg::cfg_t    cfg_q;
	popc_pkg::beat_t   in_beat, q_beat;
	popc_pkg::result_t res;
	logic deq, avail, res_valid;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cut     <= popc_pkg::CUT_RST;
			cfg_q.box     <= popc_pkg::BOX_RST;
			cfg_q.radius  <= popc_pkg::RADIUS_RST;
			cfg_q.limit   <= popc_pkg::LIMIT_RST;
			cfg_q.confirm <= popc_pkg::CONFIRM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				popc_pkg::REG_CUT:     cfg_q.cut     <= cfg_data[14:0];
				popc_pkg::REG_BOX:     cfg_q.box     <= cfg_data[14:0];
				popc_pkg::REG_RADIUS:  cfg_q.radius  <= cfg_data[14:0];
				popc_pkg::REG_LIMIT:   cfg_q.limit   <= cfg_data;
				popc_pkg::REG_CONFIRM: cfg_q.confirm <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign in_beat.req   = popc_pkg::req_t'(req_type);
	assign in_beat.x     = point_x_cm;
	assign in_beat.y     = point_y_cm;
	assign in_beat.first = first_of_set;

	popc_front u_front (.clk, .arst_n, .push, .full, .in_beat, .deq, .avail,
		.out_beat(q_beat));

	popc_back #(.PATH_DEPTH(PATH_DEPTH), .SCAN_DEPTH(SCAN_DEPTH)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .avail, .beat(q_beat), .deq,
		.res_valid, .res_take(pop), .res);

	assign empty     = !res_valid;
	assign confirmed = res.confirmed;
	assign range_cm  = res.range_cm;
	assign raw_hit   = res.raw_hit;
	assign hit_x_cm  = res.hit_x;
	assign hit_y_cm  = res.hit_y;
endmodule

/* design/popc_front.sv */
// Front end: takes request beats, drops unused codes, queues the rest.
// Depends on popc_pkg.
module popc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  popc_pkg::beat_t   in_beat,
	input  logic              deq,
	output logic              avail,
	output popc_pkg::beat_t   out_beat
);
	localparam int AW = $clog2(popc_pkg::QueueDepth);

	popc_pkg::beat_t mem_q [popc_pkg::QueueDepth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign full     = (cnt_q == (AW+1)'(popc_pkg::QueueDepth));
	assign avail    = (cnt_q != '0);
	assign out_beat = mem_q[rp_q];
	assign wr       = push && !full && (in_beat.req != popc_pkg::REQ_NONE);
	assign rd       = deq && avail;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

/* design/popc_isqrt.sv */
// Bit-serial integer square root, one result bit per cycle, 32-bit input.
// Depends on nothing beyond plain logic.
module popc_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] val,
	output logic        done,
	output logic [15:0] root
);
	logic [15:0] res_q;
	logic [4:0]  n_q;
	logic        busy_q;
	logic [17:0] trial;

	assign trial = {res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done <= 1'b0; n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; n_q <= 5'd16;
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == 5'd1) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end

	// digit recurrence: prem holds partial remainder, src_q supplies bit pairs
	logic [31:0] src_q;
	logic [19:0] part;
	logic [19:0] prem_q;
	assign part = {prem_q[17:0], src_q[31:30]};
	always_ff @(posedge clk) begin
		if (start) begin
			src_q <= val; prem_q <= '0; res_q <= '0;
		end else if (busy_q) begin
			src_q <= {src_q[29:0], 2'b00};
			if (part >= {2'b00, trial}) begin
				prem_q <= part - {2'b00, trial};
				res_q  <= {res_q[14:0], 1'b1};
			end else begin
				prem_q <= part;
				res_q  <= {res_q[14:0], 1'b0};
			end
		end
	end
	assign root = res_q;
endmodule

/* design/popc_back.sv */
// Back end: point stores, first-hit search sequencer, root, confirmation.
// Depends on popc_pkg and popc_isqrt.
module popc_back #(
	parameter int PATH_DEPTH = popc_pkg::PathDepthDef,
	parameter int SCAN_DEPTH = popc_pkg::ScanDepthDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  popc_pkg::cfg_t   cfg,
	input  logic             avail,
	input  popc_pkg::beat_t  beat,
	output logic             deq,
	output logic             res_valid,
	input  logic             res_take,
	output popc_pkg::result_t res
);
	localparam int PAW = $clog2(PATH_DEPTH);
	localparam int SAW = $clog2(SCAN_DEPTH);

	logic [31:0] pmem [PATH_DEPTH];
	logic [31:0] smem [SCAN_DEPTH];
	logic [PAW:0] pcnt_q, pidx_q;
	logic [SAW:0] scnt_q, sidx_q;
	logic [31:0]  prd_q, srd_q;
	logic         passed_q;
	logic [3:0]   ccnt_q;
	logic signed [15:0] hx_q, hy_q;
	popc_pkg::state_t st_q, st_d;

	logic signed [16:0] px, py, sx, sy, dx, dy;
	logic [16:0] adx, ady;
	logic [33:0] dx2_q, dy2_q, lim_q;
	logic        inbox_q;
	logic        hit_q;
	logic [31:0] mag_q;
	logic [31:0] psq;
	logic        sq_start, sq_done;
	logic [15:0] root;
	logic        counted, conf;
	logic [3:0]  need;

	assign px = 17'(signed'(prd_q[31:16]));
	assign py = 17'(signed'(prd_q[15:0]));
	assign sx = 17'(signed'(srd_q[31:16]));
	assign sy = 17'(signed'(srd_q[15:0]));
	assign dx = sx - px;
	assign dy = sy - py;
	assign adx = dx[16] ? 17'(-dx) : 17'(dx);
	assign ady = dy[16] ? 17'(-dy) : 17'(dy);
	// squared magnitude of the current path point, fed straight to the root
	assign psq = 32'(px * px) + 32'(py * py);

	// loads
	always_ff @(posedge clk) begin
		if (st_q == popc_pkg::ST_IDLE && avail && beat.req == popc_pkg::REQ_PATH &&
			(beat.first || pcnt_q < (PAW+1)'(PATH_DEPTH)))
			pmem[beat.first ? '0 : pcnt_q[PAW-1:0]] <= {beat.x, beat.y};
		if (st_q == popc_pkg::ST_IDLE && avail && beat.req == popc_pkg::REQ_SCAN &&
			(beat.first || scnt_q < (SAW+1)'(SCAN_DEPTH)))
			smem[beat.first ? '0 : scnt_q[SAW-1:0]] <= {beat.x, beat.y};
		prd_q <= pmem[pidx_q[PAW-1:0]];
		srd_q <= smem[sidx_q[SAW-1:0]];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			popc_pkg::ST_IDLE: if (avail && beat.req == popc_pkg::REQ_EOF)
				st_d = (pcnt_q == '0) ? popc_pkg::ST_DONE : popc_pkg::ST_PRD;
			popc_pkg::ST_PRD:  st_d = popc_pkg::ST_PCHK;
			popc_pkg::ST_PCHK: begin
				if (!passed_q && $signed(py) < $signed({2'b00, cfg.cut}))
					st_d = (pidx_q + 1'b1 >= pcnt_q) ? popc_pkg::ST_DONE : popc_pkg::ST_PRD;
				else
					st_d = (scnt_q == '0) ? popc_pkg::ST_DONE : popc_pkg::ST_SRD;
			end
			popc_pkg::ST_SRD:  st_d = popc_pkg::ST_SCHK;
			popc_pkg::ST_SCHK: st_d = popc_pkg::ST_SQ1;
			popc_pkg::ST_SQ1: begin
				if (inbox_q && dx2_q + dy2_q < lim_q) st_d = popc_pkg::ST_ROOT;
				else if (sidx_q + 1'b1 < scnt_q) st_d = popc_pkg::ST_SRD;
				else if (pidx_q + 1'b1 < pcnt_q) st_d = popc_pkg::ST_PRD;
				else st_d = popc_pkg::ST_DONE;
			end
			popc_pkg::ST_ROOT: if (sq_done) st_d = popc_pkg::ST_DONE;
			popc_pkg::ST_DONE: st_d = popc_pkg::ST_EMIT;
			popc_pkg::ST_EMIT: if (res_take) st_d = popc_pkg::ST_IDLE;
			default: st_d = popc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		deq      = (st_q == popc_pkg::ST_IDLE) && avail;
		sq_start = (st_q == popc_pkg::ST_SQ1) && (st_d == popc_pkg::ST_ROOT);
		res_valid = (st_q == popc_pkg::ST_EMIT);
	end

	assign need    = (cfg.confirm == '0) ? 4'd1 : cfg.confirm;
	assign counted = hit_q && ({16'd0, mag_q[15:0]} < 32'(cfg.limit)) && (mag_q[31:16] == '0);

	popc_isqrt u_sqrt (.clk, .arst_n, .start(sq_start), .val(psq), .done(sq_done), .root);

	always_ff @(posedge clk) begin
		if (st_q == popc_pkg::ST_SCHK) begin
			dx2_q   <= 34'(adx * adx);
			dy2_q   <= 34'(ady * ady);
			lim_q   <= 34'(cfg.radius * cfg.radius);
			inbox_q <= !($signed(sy) < $signed({2'b00, cfg.cut})) &&
				adx < {2'b00, cfg.box} && ady < {2'b00, cfg.box};
		end
		if (sq_start) mag_q <= psq;
		if (sq_done) mag_q <= {16'd0, root};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= popc_pkg::ST_IDLE; pcnt_q <= '0; scnt_q <= '0; pidx_q <= '0;
			sidx_q <= '0; passed_q <= 1'b0; hit_q <= 1'b0; ccnt_q <= '0;
			hx_q <= '0; hy_q <= '0; res <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				popc_pkg::ST_IDLE: begin
					pidx_q <= '0; sidx_q <= '0; passed_q <= 1'b0; hit_q <= 1'b0;
					if (avail && beat.req == popc_pkg::REQ_PATH) begin
						if (beat.first) pcnt_q <= (PAW+1)'(1);
						else if (pcnt_q < (PAW+1)'(PATH_DEPTH)) pcnt_q <= pcnt_q + 1'b1;
					end
					if (avail && beat.req == popc_pkg::REQ_SCAN) begin
						if (beat.first) scnt_q <= (SAW+1)'(1);
						else if (scnt_q < (SAW+1)'(SCAN_DEPTH)) scnt_q <= scnt_q + 1'b1;
					end
				end
				popc_pkg::ST_PCHK: begin
					if (!passed_q && $signed(py) < $signed({2'b00, cfg.cut}))
						pidx_q <= pidx_q + 1'b1;
					else begin
						passed_q <= 1'b1; sidx_q <= '0;
					end
				end
				popc_pkg::ST_SQ1: begin
					if (st_d == popc_pkg::ST_ROOT) begin
						hit_q <= 1'b1; hx_q <= px[15:0]; hy_q <= py[15:0];
					end else if (st_d == popc_pkg::ST_SRD) sidx_q <= sidx_q + 1'b1;
					else if (st_d == popc_pkg::ST_PRD) begin
						pidx_q <= pidx_q + 1'b1; sidx_q <= '0;
					end
				end
				popc_pkg::ST_DONE: begin
					if (counted) ccnt_q <= (ccnt_q == 4'd15) ? ccnt_q : ccnt_q + 1'b1;
					else ccnt_q <= '0;
					res.confirmed <= conf;
					res.range_cm  <= conf ? mag_q[15:0] : 16'd0;
					res.raw_hit   <= hit_q;
					res.hit_x     <= hx_q;
					res.hit_y     <= hy_q;
				end
				default: ;
			endcase
		end
	end

	assign conf = counted && ((ccnt_q == 4'd15 ? 4'd15 : ccnt_q + 1'b1) >= need);
endmodule
